@@ hw/rtl/tks_pkg.sv @@
package tks_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int ROW_W            = 16;
    localparam int ROW_IDX_W        = 4;
    localparam int VCNT_W           = 5;
    localparam int VERTEX_W         = 4;
    localparam logic [VCNT_W-1:0] VCNT_RST = 5'd16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [1:0] {
        M_DEG  = 2'd0,
        M_SEED = 2'd1,
        M_EDGE = 2'd2,
        M_OUT  = 2'd3
    } t_mode;

    typedef struct packed {
        logic deg_we;
        logic enq;
        logic emit;
    } t_act;

endpackage

@@ hw/rtl/topological_sort_kahn_unit.sv @@
// channel   | handshake                 | payload
// ----------+---------------------------+----------------------------------------
// input     | start, busy               | i_command, i_row_index, i_row_bits
// result    | o_strobe (one cycle each) | o_vertex, o_acyclic, o_last
// config    | i_cfg_we                  | i_cfg_wdata (vertex count)
//
// A row load leaves busy low.
// A run raises busy; each edge scan step reads the in-degree memory at one column while it
// writes back the column that it read before.
// The order is emitted one vertex per cycle at the end of the run; a cyclic graph ends
// earlier and gives one result in the same cycle that busy drops.
// Reset is synchronous, active low, and needs no clearing pass.
// The receiver cannot stall: each result beat stands for exactly one cycle.
module topological_sort_kahn_unit #(
    parameter int MAX_VERTICES = tks_pkg::MAX_VERTICES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [tks_pkg::ROW_IDX_W-1:0]  i_row_index,
    input  logic [tks_pkg::ROW_W-1:0]      i_row_bits,
    input  logic                           i_cfg_we,
    input  logic [tks_pkg::VCNT_W-1:0]     i_cfg_wdata,
    output logic                           o_strobe,
    output logic [tks_pkg::VERTEX_W-1:0]   o_vertex,
    output logic                           o_acyclic,
    output logic                           o_last
);
    import tks_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CLR  = 7'b0000010,
        S_ROW  = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_POP  = 7'b0010000,
        S_POPW = 7'b0100000,
        S_CYC  = 7'b1000000
    } t_state;

    logic [ROW_W-1:0] adj_mem [MAX_VERTICES];
    logic [CW-1:0]    deg_mem [MAX_VERTICES];
    logic [VW-1:0]    q_mem   [MAX_VERTICES];

    logic [ROW_W-1:0] r_adj_q;
    logic [CW-1:0]    r_deg_q;
    logic [VW-1:0]    r_q_q;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [VCNT_W-1:0]   r_vcount;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic [CW-1:0]       r_pj, n_pj;
    logic                r_p1, n_p1;
    logic [CW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_tail, n_tail;
    logic [VW-1:0]       r_v, n_v;
    logic                r_strb, n_strb;
    logic [VERTEX_W-1:0] r_vertex, n_vertex;
    logic                r_acyc, n_acyc;
    logic                r_last, n_last;

    logic          adj_we;
    logic [VW-1:0] adj_ra;
    logic          deg_we;
    logic [VW-1:0] deg_wa;
    logic [CW-1:0] deg_wd;
    logic          q_we;
    logic [VW-1:0] q_ra;
    logic [CW-1:0] vcnt_use;
    logic          edge_bit;
    t_act          act;
    logic [CW-1:0] deg_nx;

    function automatic logic edge_at(input logic [ROW_W-1:0] row, input logic [CW-1:0] j);
        logic b;
        b = 1'b0;
        for (int k = 0; k < ROW_W; k++) begin
            if (k == int'(j)) begin
                b = row[k];
            end
        end
        return b;
    endfunction

    assign vcnt_use = (r_vcount == '0) ? CW'(1) :
                      (int'(r_vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(r_vcount);
    assign adj_we   = (r_state == S_IDLE) && start && (i_command == CMD_LOAD)
                      && (int'(i_row_index) < MAX_VERTICES);
    assign adj_ra   = (r_mode == M_DEG) ? r_i[VW-1:0] : r_v;
    assign q_ra     = (r_state == S_POP) ? r_head[VW-1:0] : r_j[VW-1:0];
    assign edge_bit = edge_at(r_adj_q, r_pj);
    assign q_we     = act.enq;

    tks_alu #(
        .DW (CW)
    ) u_alu (
        .i_mode   (r_mode),
        .i_valid  (r_p1 && (r_state == S_SCAN)),
        .i_edge   (edge_bit),
        .i_room   (r_tail < r_n),
        .i_deg    (r_deg_q),
        .o_act    (act),
        .o_deg_nx (deg_nx)
    );

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_pj     = r_pj;
        n_p1     = 1'b0;
        n_head   = r_head;
        n_tail   = r_tail;
        n_v      = r_v;
        n_strb   = 1'b0;
        n_vertex = r_vertex;
        n_acyc   = r_acyc;
        n_last   = r_last;
        deg_we   = 1'b0;
        deg_wa   = r_pj[VW-1:0];
        deg_wd   = deg_nx;

        case (r_state)
            S_IDLE: begin
                if (start && (i_command == CMD_RUN)) begin
                    n_n     = vcnt_use;
                    n_j     = '0;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                deg_we = 1'b1;
                deg_wa = r_j[VW-1:0];
                deg_wd = '0;
                n_j    = r_j + CW'(1);
                if (r_j == r_n - CW'(1)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_mode  = M_DEG;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                deg_we = act.deg_we;
                if (act.enq) begin
                    n_tail = r_tail + CW'(1);
                end
                if (act.emit) begin
                    n_strb   = 1'b1;
                    n_vertex = VERTEX_W'(r_q_q);
                    n_acyc   = 1'b1;
                    n_last   = (r_pj == r_n - CW'(1));
                end
                if (r_j < r_n) begin
                    n_j  = r_j + CW'(1);
                    n_p1 = 1'b1;
                    n_pj = r_j;
                end else if (!r_p1) begin
                    case (r_mode)
                        M_DEG: begin
                            n_j = '0;
                            if (r_i == r_n - CW'(1)) begin
                                n_mode = M_SEED;
                                n_head = '0;
                                n_tail = '0;
                            end else begin
                                n_i     = r_i + CW'(1);
                                n_state = S_ROW;
                            end
                        end
                        M_SEED: begin
                            n_state = S_POP;
                        end
                        M_EDGE: begin
                            n_state = S_POP;
                        end
                        M_OUT: begin
                            n_state = S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_j = '0;
                if (r_head < r_tail) begin
                    n_head  = r_head + CW'(1);
                    n_state = S_POPW;
                end else if (r_head == r_n) begin
                    n_mode  = M_OUT;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_CYC;
                end
            end
            S_POPW: begin
                n_v     = r_q_q;
                n_mode  = M_EDGE;
                n_j     = '0;
                n_state = S_ROW;
            end
            S_CYC: begin
                n_strb   = 1'b1;
                n_vertex = '0;
                n_acyc   = 1'b0;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            adj_mem[VW'(i_row_index)] <= i_row_bits;
        end
        r_adj_q <= adj_mem[adj_ra];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            deg_mem[deg_wa] <= deg_wd;
        end
        r_deg_q <= deg_mem[r_j[VW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[r_tail[VW-1:0]] <= r_pj[VW-1:0];
        end
        r_q_q <= q_mem[q_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= M_DEG;
            r_vcount <= VCNT_RST;
            r_n      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_pj     <= '0;
            r_p1     <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_v      <= '0;
            r_strb   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            r_state <= n_state;
            r_mode  <= n_mode;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_pj    <= n_pj;
            r_p1    <= n_p1;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_v     <= n_v;
            r_strb  <= n_strb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vertex <= n_vertex;
        r_acyc   <= n_acyc;
        r_last   <= n_last;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_strobe  = r_strb;
    assign o_vertex  = r_vertex;
    assign o_acyclic = r_acyc;
    assign o_last    = r_last;

endmodule

@@ hw/rtl/tks_alu.sv @@
module tks_alu #(
    parameter int DW = 5
) (
    input  tks_pkg::t_mode i_mode,
    input  logic           i_valid,
    input  logic           i_edge,
    input  logic           i_room,
    input  logic [DW-1:0]  i_deg,
    output tks_pkg::t_act  o_act,
    output logic [DW-1:0]  o_deg_nx
);
    import tks_pkg::*;

    logic zero;
    logic one;

    assign zero     = (i_deg == '0);
    assign one      = (i_deg == DW'(1));
    assign o_deg_nx = i_deg + ((i_mode == M_EDGE) ? {DW{1'b1}} : DW'(1));

    always_comb begin
        o_act = '0;
        case (i_mode)
            M_DEG: begin
                o_act.deg_we = i_valid && i_edge;
            end
            M_SEED: begin
                o_act.enq = i_valid && zero && i_room;
            end
            M_EDGE: begin
                o_act.deg_we = i_valid && i_edge && !zero;
                o_act.enq    = i_valid && i_edge && one && i_room;
            end
            M_OUT: begin
                o_act.emit = i_valid;
            end
            default: begin
                o_act = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/tks_checker.sv @@
module tks_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_command,
    input logic       o_strobe,
    input logic [3:0] o_vertex,
    input logic       o_acyclic,
    input logic       o_last
);
    import tks_pkg::*;

    a_cyclic_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_acyclic |-> o_last && (o_vertex == 4'd0))
        else $error("cyclic beat not final or vertex nonzero");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_command == CMD_LOAD) |=> !busy)
        else $error("row load raised busy");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_command == CMD_RUN) |=> busy)
        else $error("run did not raise busy");

    a_order_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("gap inside vertex order");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("beat after final result");

endmodule

bind topological_sort_kahn_unit tks_checker u_tks_checker (.*);

@@ dv/tb_topological_sort_kahn_unit.sv @@
`timescale 1ns / 1ps

module tb_topological_sort_kahn_unit;
    import tks_pkg::*;

    localparam int NV          = MAX_VERTICES_DEF;
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                acyclic;
        logic                last;
    } t_order_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_command;
    logic [ROW_IDX_W-1:0] i_row_index;
    logic [ROW_W-1:0]     i_row_bits;
    logic                 i_cfg_we;
    logic [VCNT_W-1:0]    i_cfg_wdata;
    logic                 o_strobe;
    logic [VERTEX_W-1:0]  o_vertex;
    logic                 o_acyclic;
    logic                 o_last;

    logic [ROW_W-1:0]  adj_rows [NV];
    logic [VCNT_W-1:0] count_reg;
    t_order_beat       order_q [$];
    int                error_count = 0;
    int                idle_pct    = 31;
    int                items_sent  = 0;
    int                cycle_count = 0;

    topological_sort_kahn_unit #(
        .MAX_VERTICES(NV)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_command  (i_command),
        .i_row_index(i_row_index),
        .i_row_bits (i_row_bits),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_vertex   (o_vertex),
        .o_acyclic  (o_acyclic),
        .o_last     (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned active_count();
        if (count_reg == 0) return 1;
        if (count_reg > NV) return NV;
        return 32'(count_reg);
    endfunction

    // Kahn order over the rows in use; one beat per vertex, or one cyclic beat
    function automatic void predict_order();
        int unsigned         n;
        int unsigned         head;
        int unsigned         tail;
        logic [VCNT_W-1:0]   indeg [NV];
        logic [VERTEX_W-1:0] ready [NV];
        logic [VERTEX_W-1:0] v;
        t_order_beat         b;
        n = active_count();
        for (int j = 0; j < NV; j++) indeg[j] = '0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (adj_rows[i][j]) indeg[j] = indeg[j] + 1'b1;
        head = 0;
        tail = 0;
        for (int j = 0; j < n; j++) begin
            if (indeg[j] == 0) begin
                ready[tail] = VERTEX_W'(j);
                tail++;
            end
        end
        while (head < tail) begin
            v = ready[head];
            head++;
            for (int j = 0; j < n; j++) begin
                if (adj_rows[v][j] && indeg[j] != 0) begin
                    indeg[j] = indeg[j] - 1'b1;
                    if (indeg[j] == 0) begin
                        ready[tail] = VERTEX_W'(j);
                        tail++;
                    end
                end
            end
        end
        if (tail != n) begin
            b.vertex  = '0;
            b.acyclic = 1'b0;
            b.last    = 1'b1;
            order_q.insert(order_q.size(), b);
        end else begin
            for (int i = 0; i < n; i++) begin
                b.vertex  = ready[i];
                b.acyclic = 1'b1;
                b.last    = (i == n - 1);
                order_q.insert(order_q.size(), b);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (order_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat: vertex %0d acyclic %0b last %0b",
                                          o_vertex, o_acyclic, o_last));
            end else begin
                if (o_vertex !== order_q[0].vertex)
                    report_mismatch($sformatf("vertex: got %0d, want %0d",
                                              o_vertex, order_q[0].vertex));
                if (o_acyclic !== order_q[0].acyclic)
                    report_mismatch($sformatf("acyclic: got %0b, want %0b",
                                              o_acyclic, order_q[0].acyclic));
                if (o_last !== order_q[0].last)
                    report_mismatch($sformatf("last: got %0b, want %0b",
                                              o_last, order_q[0].last));
                order_q.delete(0);
            end
        end
    end

    // hold start high across back-to-back beats; drop it only for a gap
    task automatic send_beat(input logic cmd, input logic [ROW_IDX_W-1:0] idx,
                             input logic [ROW_W-1:0] bits);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_command   <= cmd;
        i_row_index <= idx;
        i_row_bits  <= bits;
        do @(posedge i_clk); while (busy);
        if (cmd == CMD_LOAD) adj_rows[idx] = bits;
        else predict_order();
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (order_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_count(input int unsigned value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= VCNT_W'(value);
        @(posedge i_clk);
        count_reg = VCNT_W'(value);
        i_cfg_we <= 1'b0;
    endtask

    // full upper triangle at the reset count: order is 0..15
    task automatic test_reset_order();
        for (int i = 0; i < NV; i++)
            send_beat(CMD_LOAD, ROW_IDX_W'(i), 16'hFFFF << (i + 1));
        send_beat(CMD_RUN, '0, '0);
    endtask

    task automatic test_self_loop();
        send_beat(CMD_LOAD, 4'd15, 16'h8000);
        send_beat(CMD_RUN, 4'd15, 16'hFFFF);
    endtask

    task automatic test_count_limits();
        write_count(0);
        send_beat(CMD_RUN, '0, '0);
        send_beat(CMD_LOAD, 4'd0, 16'h0001);
        send_beat(CMD_RUN, '0, '0);
        write_count(31);
        send_beat(CMD_LOAD, 4'd0, 16'hFFFE);
        send_beat(CMD_LOAD, 4'd15, 16'h0001);
        send_beat(CMD_RUN, '0, '0);
        write_count(17);
        send_beat(CMD_LOAD, 4'd15, 16'h0000);
        send_beat(CMD_RUN, '0, '0);
    endtask

    task automatic test_random_graphs(input int budget);
        int                  first;
        int unsigned         n;
        int unsigned         density;
        int unsigned         kind;
        int unsigned         off;
        int unsigned         idx;
        int unsigned         value;
        int unsigned         a;
        int unsigned         b;
        logic                rev;
        logic [ROW_W-1:0]    low_mask;
        logic [VERTEX_W-1:0] tmp;
        logic [VERTEX_W-1:0] perm [NV];
        logic [ROW_W-1:0]    rows [NV];
        first = items_sent;
        while (items_sent - first < budget) begin
            idle_pct = (items_sent - first >= budget / 3 &&
                        items_sent - first < budget / 2) ? 0 : 31;
            if (items_sent == first || $urandom_range(3) == 0) begin
                case ($urandom_range(7))
                    0:       value = 0;
                    1:       value = 1;
                    2:       value = 16;
                    3:       value = 31;
                    default: value = $urandom_range(31);
                endcase
                write_count(value);
            end
            n = active_count();
            low_mask = ROW_W'((32'd1 << n) - 1);
            for (int i = 0; i < NV; i++) perm[i] = VERTEX_W'(i);
            for (int i = n - 1; i > 0; i--) begin
                idx = $urandom_range(i);
                tmp = perm[i];
                perm[i] = perm[idx];
                perm[idx] = tmp;
            end
            // garbage above the count is ignored by the block
            for (int i = 0; i < NV; i++) rows[i] = ROW_W'($urandom) & ~low_mask;
            density = $urandom_range(100);
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if ($urandom_range(99) < density) rows[perm[i]][perm[j]] = 1'b1;
            kind = $urandom_range(9);
            if (kind == 7 && n > 1) begin
                a = $urandom_range(n - 2);
                b = $urandom_range(n - 1, a + 1);
                rows[perm[b]][perm[a]] = 1'b1;
            end else if (kind == 7 || kind == 8) begin
                a = $urandom_range(n - 1);
                rows[a][a] = 1'b1;
            end else if (kind == 9) begin
                for (int i = 0; i < n; i++) rows[i] = ROW_W'($urandom);
            end
            off = $urandom_range(n - 1);
            rev = $urandom_range(1);
            for (int k = 0; k < n; k++) begin
                idx = (k + off) % n;
                if (rev) idx = n - 1 - idx;
                send_beat(CMD_LOAD, ROW_IDX_W'(idx), rows[idx]);
            end
            if (n < NV && $urandom_range(3) == 0)
                send_beat(CMD_LOAD, ROW_IDX_W'($urandom_range(NV - 1, n)), ROW_W'($urandom));
            send_beat(CMD_RUN, ROW_IDX_W'($urandom), ROW_W'($urandom));
            if ($urandom_range(4) == 0)
                send_beat(CMD_RUN, ROW_IDX_W'($urandom), ROW_W'($urandom));
        end
        idle_pct = 31;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_command   <= CMD_LOAD;
        i_row_index <= '0;
        i_row_bits  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        count_reg = VCNT_RST;

        test_reset_order();
        test_self_loop();
        test_count_limits();
        test_random_graphs(330);

        start <= 1'b0;
        for (int k = 0; k < 4000 && order_q.size() != 0; k++) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (order_q.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived", order_q.size()));
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
